>>> rtl/disk_brush_tile_stamp_assert.svh
// Assertion macros for the disk brush stamp checker.
// Expects clk and arst_n in the scope that uses them.
`ifndef DISK_BRUSH_TILE_STAMP_ASSERT_SVH
`define DISK_BRUSH_TILE_STAMP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DBTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define DBTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/dbts_pkg.sv
// Shared types and constants of the disk brush stamp block.
// No dependencies; used by the top level and its checker.
package dbts_pkg;

	// Default parameter values
	localparam int MAX_BRUSH_SIZE_DEF = 62;
	localparam int MAP_DIM_MAX_DEF    = 1024;

	// Field and register widths
	localparam int SIZE_W     = 6;
	localparam int DIM_CFG_W  = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int COORD_W    = 12;
	localparam int TILE_W     = 12;
	localparam int COL_W      = 10;
	localparam int VAL_W      = 13;

	// Internal widths: offsets, squares, disk test, map positions
	localparam int OFS_W  = 7;
	localparam int MAG_W  = 6;
	localparam int SQ_W   = 12;
	localparam int DD_W   = 13;
	localparam int TEST_W = 15;
	localparam int POS_W  = 14;

	// Blank tile written in erase mode (-1)
	localparam logic [VAL_W-1:0] BLANK_VALUE = '1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BRUSH_SIZE,
		CFG_BRUSH_MODE,
		CFG_MAP_WIDTH,
		CFG_MAP_HEIGHT
	} cfg_idx_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_FLUSH
	} state_t;

endpackage

>>> rtl/disk_brush_tile_stamp.sv
// Disk brush stamp: walks the brush columns and reports clipped vertical spans.
// Depends on dbts_pkg.
//
// An item is taken when start is high and busy is low; busy then stays high until the
// last span of the stamp has been shown. A stamp passes through a setup step, the walk
// over the brush columns, in which the half-height is grown or shrunk one step at a time
// before each column is resolved, a flush step and, when the stamp has spans, the showing
// of the final span. Each walk step uses the single disk test unit (two small squares, an
// add and a compare against size*size+size). Each span is on column_x, row_first,
// row_last and tile_value for one cycle with result_strobe high and must be taken then;
// last_span marks the final span. A stamp that lies fully outside the map gives no spans.
// Configuration writes are taken at once through cfg_we and must only happen while busy
// is low.
module disk_brush_tile_stamp #(
	parameter int MAX_BRUSH_SIZE = dbts_pkg::MAX_BRUSH_SIZE_DEF,
	parameter int MAP_DIM_MAX    = dbts_pkg::MAP_DIM_MAX_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [dbts_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dbts_pkg::CFG_DATA_W-1:0]       cfg_data,
	// command
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [dbts_pkg::COORD_W-1:0]   center_x,
	input  logic signed [dbts_pkg::COORD_W-1:0]   center_y,
	input  logic [dbts_pkg::TILE_W-1:0]           tile_type,
	// results
	output logic                                  result_strobe,
	output logic [dbts_pkg::COL_W-1:0]            column_x,
	output logic [dbts_pkg::COL_W-1:0]            row_first,
	output logic [dbts_pkg::COL_W-1:0]            row_last,
	output logic signed [dbts_pkg::VAL_W-1:0]     tile_value,
	output logic                                  last_span
);

	localparam int SIZE_W = dbts_pkg::SIZE_W;
	localparam int DIM_W  = dbts_pkg::DIM_CFG_W;
	localparam int OFS_W  = dbts_pkg::OFS_W;
	localparam int MAG_W  = dbts_pkg::MAG_W;
	localparam int SQ_W   = dbts_pkg::SQ_W;
	localparam int DD_W   = dbts_pkg::DD_W;
	localparam int TEST_W = dbts_pkg::TEST_W;
	localparam int POS_W  = dbts_pkg::POS_W;
	localparam int COL_W  = dbts_pkg::COL_W;
	localparam int VAL_W  = dbts_pkg::VAL_W;
	localparam int COORD_W = dbts_pkg::COORD_W;

	localparam logic [SIZE_W-1:0]       MAX_SIZE_C = SIZE_W'(MAX_BRUSH_SIZE);
	localparam logic signed [POS_W-1:0] DIM_MAX_C  = POS_W'(MAP_DIM_MAX);

	// Configuration registers
	logic [SIZE_W-1:0] brush_size_q;
	logic              brush_mode_q;
	logic [DIM_W-1:0]  map_width_q;
	logic [DIM_W-1:0]  map_height_q;

	// Item and walk registers
	dbts_pkg::state_t         state_q, state_d;
	logic signed [COORD_W-1:0] cx_q, cy_q;
	logic [VAL_W-1:0]          value_q;
	logic [DD_W-1:0]           dd_q;
	logic [MAG_W-1:0]          r_q;
	logic signed [OFS_W-1:0]   dx_q;
	logic signed [OFS_W-1:0]   h_q;

	// Pending span, held until the next one shows whether it is the last
	logic             pend_v_q;
	logic [COL_W-1:0] pend_x_q, pend_y0_q, pend_y1_q;

	// Output registers
	logic             result_strobe_q;
	logic [COL_W-1:0] column_x_q, row_first_q, row_last_q;
	logic [VAL_W-1:0] tile_value_q;
	logic             last_span_q;

	// Control decoded from the state
	logic accept, setup_en, walk_en, flush_en;
	logic grow_en, shrink_en, resolve_en, at_end;

	// Shared disk test unit
	logic [SIZE_W-1:0]       size_sat;
	logic [MAG_W-1:0]        r_new;
	logic [DD_W-1:0]         dd_new;
	logic                    left_half;
	logic [MAG_W-1:0]        dx_mag, dy_mag;
	logic [SQ_W-1:0]         dx_sq, dy_sq;
	logic [TEST_W-1:0]       dist4;
	logic                    fits;
	logic signed [OFS_W-1:0] dy_sel, r_ext;

	// Column clipping
	logic signed [POS_W-1:0] map_w, map_h, pos_x, y_lo, y_hi, y_lo_c, y_hi_c;
	logic                    col_ok;

	// Hold configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brush_size_q <= SIZE_W'(1);
			brush_mode_q <= 1'b0;
			map_width_q  <= DIM_W'(1024);
			map_height_q <= DIM_W'(1024);
		end else if (cfg_we) begin
			case (cfg_index)
				dbts_pkg::CFG_BRUSH_SIZE: brush_size_q <= cfg_data[SIZE_W-1:0];
				dbts_pkg::CFG_BRUSH_MODE: brush_mode_q <= cfg_data[0];
				dbts_pkg::CFG_MAP_WIDTH:  map_width_q  <= cfg_data[DIM_W-1:0];
				dbts_pkg::CFG_MAP_HEIGHT: map_height_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Brush geometry from the saturated size
	always_comb begin
		size_sat = (brush_size_q > MAX_SIZE_C) ? MAX_SIZE_C : brush_size_q;
		r_new    = MAG_W'(size_sat >> 1) + MAG_W'(1);
		dd_new   = DD_W'(size_sat) * DD_W'(size_sat) + DD_W'(size_sat);
	end

	// Disk test: 4*(dx^2 + dy^2) < size^2 + size
	always_comb begin
		left_half = (dx_q <= 0);
		dy_sel    = left_half ? (h_q + OFS_W'(1)) : h_q;
		dx_mag    = dx_q[OFS_W-1] ? MAG_W'(-dx_q) : MAG_W'(dx_q);
		dy_mag    = dy_sel[MAG_W-1:0];
		dx_sq     = SQ_W'(dx_mag) * SQ_W'(dx_mag);
		dy_sq     = SQ_W'(dy_mag) * SQ_W'(dy_mag);
		dist4     = {TEST_W'(dx_sq) + TEST_W'(dy_sq)} << 2;
		fits      = (dist4 < TEST_W'(dd_q));
		r_ext     = $signed({1'b0, r_q});
	end

	// Clip the current column against the map
	always_comb begin
		map_w  = ($signed(POS_W'(map_width_q)) > DIM_MAX_C) ? DIM_MAX_C
		         : $signed(POS_W'(map_width_q));
		map_h  = ($signed(POS_W'(map_height_q)) > DIM_MAX_C) ? DIM_MAX_C
		         : $signed(POS_W'(map_height_q));
		pos_x  = $signed({{(POS_W-COORD_W){cx_q[COORD_W-1]}}, cx_q})
		         + $signed({{(POS_W-OFS_W){dx_q[OFS_W-1]}}, dx_q});
		y_lo   = $signed({{(POS_W-COORD_W){cy_q[COORD_W-1]}}, cy_q})
		         - $signed({{(POS_W-OFS_W){h_q[OFS_W-1]}}, h_q});
		y_hi   = $signed({{(POS_W-COORD_W){cy_q[COORD_W-1]}}, cy_q})
		         + $signed({{(POS_W-OFS_W){h_q[OFS_W-1]}}, h_q});
		y_lo_c = (y_lo < 0) ? '0 : y_lo;
		y_hi_c = (y_hi > map_h - POS_W'(1)) ? (map_h - POS_W'(1)) : y_hi;
		col_ok = !h_q[OFS_W-1] && (pos_x >= 0) && (pos_x < map_w) && (y_lo_c <= y_hi_c);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dbts_pkg::ST_IDLE:  if (accept) state_d = dbts_pkg::ST_SETUP;
			dbts_pkg::ST_SETUP: state_d = dbts_pkg::ST_WALK;
			dbts_pkg::ST_WALK:  if (resolve_en && at_end) state_d = dbts_pkg::ST_FLUSH;
			dbts_pkg::ST_FLUSH: state_d = dbts_pkg::ST_IDLE;
			default:            state_d = dbts_pkg::ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer
	always_comb begin
		busy       = (state_q != dbts_pkg::ST_IDLE) || result_strobe_q;
		accept     = start && !busy;
		setup_en   = (state_q == dbts_pkg::ST_SETUP);
		walk_en    = (state_q == dbts_pkg::ST_WALK);
		flush_en   = (state_q == dbts_pkg::ST_FLUSH);
		at_end     = (dx_q == r_ext);
		grow_en    = 1'b0;
		shrink_en  = 1'b0;
		resolve_en = 1'b0;
		if (walk_en) begin
			if (left_half) begin
				if (fits && (h_q < r_ext)) grow_en = 1'b1;
				else resolve_en = 1'b1;
			end else begin
				if (!h_q[OFS_W-1] && !fits) shrink_en = 1'b1;
				else resolve_en = 1'b1;
			end
		end
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dbts_pkg::ST_IDLE;
			pend_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (setup_en) pend_v_q <= 1'b0;
			else if (resolve_en && col_ok) pend_v_q <= 1'b1;
		end
	end

	// Latch the item and walk the columns
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			value_q <= brush_mode_q ? dbts_pkg::BLANK_VALUE : VAL_W'(tile_type);
		end
		if (setup_en) begin
			dd_q <= dd_new;
			r_q  <= r_new;
			dx_q <= -$signed({1'b0, r_new});
			h_q  <= '1;
		end else if (grow_en) begin
			h_q <= h_q + OFS_W'(1);
		end else if (shrink_en) begin
			h_q <= h_q - OFS_W'(1);
		end else if (resolve_en) begin
			dx_q <= dx_q + OFS_W'(1);
		end
		if (resolve_en && col_ok) begin
			pend_x_q  <= pos_x[COL_W-1:0];
			pend_y0_q <= y_lo_c[COL_W-1:0];
			pend_y1_q <= y_hi_c[COL_W-1:0];
		end
	end

	// Drive the span strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe_q <= 1'b0;
		end else begin
			result_strobe_q <= pend_v_q && ((resolve_en && col_ok) || flush_en);
		end
	end

	// Hold span payload for its cycle
	always_ff @(posedge clk) begin
		if (pend_v_q && ((resolve_en && col_ok) || flush_en)) begin
			column_x_q   <= pend_x_q;
			row_first_q  <= pend_y0_q;
			row_last_q   <= pend_y1_q;
			tile_value_q <= value_q;
			last_span_q  <= flush_en;
		end
	end

	assign result_strobe = result_strobe_q;
	assign column_x      = column_x_q;
	assign row_first     = row_first_q;
	assign row_last      = row_last_q;
	assign tile_value    = $signed(tile_value_q);
	assign last_span     = last_span_q;

endmodule

>>> rtl/dbts_checker.sv
// Port-level checks of the disk brush stamp, bound to the top level.
// Depends on dbts_pkg and disk_brush_tile_stamp_assert.svh.
`include "disk_brush_tile_stamp_assert.svh"

module dbts_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           result_strobe,
	input logic [dbts_pkg::COL_W-1:0]     column_x,
	input logic [dbts_pkg::COL_W-1:0]     row_first,
	input logic [dbts_pkg::COL_W-1:0]     row_last,
	input logic                           last_span
);

	// Spans show only while a stamp is in progress
	`DBTS_ASSERT_NOW(a_strobe_busy, result_strobe, busy, "span shown while not busy")

	// An accepted item makes the block busy
	`DBTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

	// The final span of a stamp is not followed directly by another
	`DBTS_ASSERT_NEXT(a_last_alone, result_strobe && last_span, !result_strobe,
		"span right after the final span")

	// A span never runs upward
	`DBTS_ASSERT_NOW(a_span_order, result_strobe, row_first <= row_last,
		"span with first row below last row")

	// Columns of one stamp rise strictly
	`DBTS_ASSERT_NEXT(a_col_rise, result_strobe && !last_span,
		!result_strobe || (column_x > $past(column_x)), "span columns out of order")

endmodule

bind disk_brush_tile_stamp dbts_checker u_dbts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.column_x      (column_x),
	.row_first     (row_first),
	.row_last      (row_last),
	.last_span     (last_span)
);

>>> verif/testbench.sv
// Self-checking testbench for disk_brush_tile_stamp: directed and random brush stamps.
// Each accepted item is expanded into its expected column spans and compared span by span.
// Depends on dbts_pkg and the disk_brush_tile_stamp RTL.
`timescale 1ns / 1ps

module testbench;
	import dbts_pkg::*;

	localparam int SIZE_CAP     = MAX_BRUSH_SIZE_DEF;
	localparam int DIM_CAP      = MAP_DIM_MAX_DEF;
	localparam int QUIET_CYCLES = 150;
	localparam int DRAIN_GUARD  = 20000;
	localparam int CYCLE_LIMIT  = 500000;

	// One vertical write span of a stamp
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] row_top;
		logic [COL_W-1:0] row_bot;
		logic [VAL_W-1:0] value;
		logic             tail;
	} span_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic start;
	logic busy;
	logic signed [COORD_W-1:0] center_x;
	logic signed [COORD_W-1:0] center_y;
	logic [TILE_W-1:0] tile_type;
	logic result_strobe;
	logic [COL_W-1:0] column_x;
	logic [COL_W-1:0] row_first;
	logic [COL_W-1:0] row_last;
	logic signed [VAL_W-1:0] tile_value;
	logic last_span;

	// Register shadow, as written
	int unsigned brush_size_reg;
	int unsigned brush_mode_reg;
	int unsigned map_width_reg;
	int unsigned map_height_reg;

	span_t spans_due[$];
	int error_count = 0;
	int cycle_count = 0;
	int idle_pct = 0;

	disk_brush_tile_stamp uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.center_x(center_x),
		.center_y(center_y),
		.tile_type(tile_type),
		.result_strobe(result_strobe),
		.column_x(column_x),
		.row_first(row_first),
		.row_last(row_last),
		.tile_value(tile_value),
		.last_span(last_span)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** disk_brush_tile_stamp: FAILED **");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	// Append one expected span at the tail of the queue
	function automatic void queue_span(input span_t s);
		spans_due = {spans_due, s};
	endfunction

	// Expand one stamp into its clipped column spans, in column order
	function automatic void predict_stamp(input logic signed [COORD_W-1:0] cx_in,
			input logic signed [COORD_W-1:0] cy_in, input logic [TILE_W-1:0] tile);
		int cx, cy, size, r, dd, w, h, x, half, y0, y1, n;
		logic [VAL_W-1:0] val;
		span_t held;
		cx = int'(cx_in);
		cy = int'(cy_in);
		size = (brush_size_reg > SIZE_CAP) ? SIZE_CAP : int'(brush_size_reg);
		r = (size >> 1) + 1;
		dd = size * size + size;
		w = (map_width_reg > DIM_CAP) ? DIM_CAP : int'(map_width_reg);
		h = (map_height_reg > DIM_CAP) ? DIM_CAP : int'(map_height_reg);
		val = brush_mode_reg[0] ? BLANK_VALUE : {1'b0, tile};
		held = '0;
		n = 0;
		for (int dx = -r; dx <= r; dx++) begin
			x = cx + dx;
			half = -1;
			// widest row offset still inside the disk for this column
			for (int dy = 0; dy <= r; dy++)
				if ((dx * dx + dy * dy) * 4 < dd)
					half = dy;
			y0 = cy - half;
			y1 = cy + half;
			if (y0 < 0)
				y0 = 0;
			if (y1 > h - 1)
				y1 = h - 1;
			if (x >= 0 && x < w && half >= 0 && y0 <= y1) begin
				if (n > 0)
					queue_span(held);
				held.col = x[COL_W-1:0];
				held.row_top = y0[COL_W-1:0];
				held.row_bot = y1[COL_W-1:0];
				held.value = val;
				held.tail = 1'b0;
				n++;
			end
		end
		// flag the final span of the stamp
		if (n > 0) begin
			held.tail = 1'b1;
			queue_span(held);
		end
	endfunction

	// Check each span against the oldest expectation
	always @(posedge clk) begin
		span_t want;
		if (arst_n && result_strobe) begin
			if (spans_due.size() == 0) begin
				report_mismatch($sformatf("unexpected span col %0d rows %0d..%0d val %0d last %0b",
					column_x, row_first, row_last, tile_value, last_span));
			end else begin
				want = spans_due.pop_front();
				if (column_x !== want.col || row_first !== want.row_top ||
						row_last !== want.row_bot || tile_value !== want.value ||
						last_span !== want.tail)
					report_mismatch($sformatf(
						"got col %0d rows %0d..%0d val %0h last %0b, want col %0d rows %0d..%0d val %0h last %0b",
						column_x, row_first, row_last, tile_value, last_span,
						want.col, want.row_top, want.row_bot, want.value, want.tail));
			end
		end
	end

	// Offer one item until the block takes it, idling at random
	task automatic send_stamp(input logic signed [COORD_W-1:0] cx,
			input logic signed [COORD_W-1:0] cy, input logic [TILE_W-1:0] tile);
		bit taken;
		taken = 1'b0;
		if (idle_pct > 0 && $urandom_range(99) < 3) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 140)) @(posedge clk);
		end
		center_x <= cx;
		center_y <= cy;
		tile_type <= tile;
		while (!taken) begin
			if ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				@(posedge clk);
			end else begin
				start <= 1'b1;
				@(posedge clk);
				taken = !busy;
			end
		end
		predict_stamp(cx, cy, tile);
	endtask

	// Stop sending and wait until every span has arrived and the block is quiet
	task automatic settle;
		int guard;
		guard = 0;
		start <= 1'b0;
		while (spans_due.size() != 0 && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		repeat (QUIET_CYCLES) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_BRUSH_SIZE: brush_size_reg = 32'(val[SIZE_W-1:0]);
			CFG_BRUSH_MODE: brush_mode_reg = 32'(val[0]);
			CFG_MAP_WIDTH:  map_width_reg = 32'(val[DIM_CFG_W-1:0]);
			CFG_MAP_HEIGHT: map_height_reg = 32'(val[DIM_CFG_W-1:0]);
			default: ;
		endcase
	endtask

	// Reset values: unit brush on a full map, coordinate and tile extremes
	task automatic test_reset_defaults;
		send_stamp(12'sd0, 12'sd0, 12'h000);
		send_stamp(12'sd1023, 12'sd1023, 12'hFFF);
		send_stamp(-12'sd2048, -12'sd2048, 12'hFFF);
		send_stamp(12'sd2047, 12'sd2047, 12'hAAA);
		send_stamp(-12'sd2048, 12'sd2047, 12'h555);
		settle();
	endtask

	// Largest brush, zero brush and a saturated brush size
	task automatic test_brush_extremes;
		write_reg(CFG_BRUSH_SIZE, 62);
		send_stamp(12'sd512, 12'sd512, 12'h123);
		send_stamp(12'sd0, 12'sd0, 12'hFFF);
		send_stamp(12'sd1055, 12'sd1055, 12'h007);
		send_stamp(-12'sd32, -12'sd32, 12'h001);
		settle();
		write_reg(CFG_BRUSH_SIZE, 0);
		send_stamp(12'sd10, 12'sd10, 12'h005);
		settle();
		write_reg(CFG_BRUSH_SIZE, 63);
		send_stamp(12'sd600, 12'sd600, 12'h009);
		settle();
	endtask

	// Erase writes the blank value, clipped or not
	task automatic test_erase_mode;
		write_reg(CFG_BRUSH_MODE, 1);
		send_stamp(12'sd100, 12'sd100, 12'hFFF);
		send_stamp(-12'sd40, 12'sd5, 12'h000);
		settle();
		write_reg(CFG_BRUSH_MODE, 0);
	endtask

	// Empty, saturated and single-cell maps
	task automatic test_map_clipping;
		write_reg(CFG_BRUSH_SIZE, 20);
		write_reg(CFG_MAP_WIDTH, 0);
		send_stamp(12'sd5, 12'sd5, 12'h001);
		settle();
		write_reg(CFG_MAP_WIDTH, 2047);
		write_reg(CFG_MAP_HEIGHT, 0);
		send_stamp(12'sd5, 12'sd5, 12'h002);
		settle();
		write_reg(CFG_MAP_HEIGHT, 1025);
		send_stamp(12'sd1020, 12'sd1020, 12'h003);
		send_stamp(-12'sd5, 12'sd1030, 12'h004);
		settle();
		write_reg(CFG_BRUSH_SIZE, 5);
		write_reg(CFG_MAP_WIDTH, 1);
		write_reg(CFG_MAP_HEIGHT, 1);
		send_stamp(12'sd0, 12'sd0, 12'h800);
		send_stamp(12'sd3, -12'sd2, 12'h7FF);
		send_stamp(12'sd1, 12'sd1, 12'h0F0);
		settle();
		write_reg(CFG_BRUSH_SIZE, 2);
		write_reg(CFG_MAP_WIDTH, 1024);
		write_reg(CFG_MAP_HEIGHT, 1024);
		send_stamp(12'sd0, 12'sd1023, 12'h00F);
		settle();
	endtask

	// Random settings per phase; most centers land on or near the map
	task automatic test_random_stamps;
		int eff_w, eff_h, r, cx, cy;
		for (int phase = 0; phase < 9; phase++) begin
			idle_pct = (phase < 3) ? 11 : (phase < 6) ? 69 : 0;
			settle();
			write_reg(CFG_BRUSH_SIZE, $urandom_range(63));
			write_reg(CFG_BRUSH_MODE, $urandom_range(1));
			case ($urandom_range(4))
				0: write_reg(CFG_MAP_WIDTH, $urandom_range(1, 40));
				1: write_reg(CFG_MAP_WIDTH, 1024);
				2: write_reg(CFG_MAP_WIDTH, $urandom_range(1025, 2047));
				default: write_reg(CFG_MAP_WIDTH, $urandom_range(1, 1023));
			endcase
			case ($urandom_range(4))
				0: write_reg(CFG_MAP_HEIGHT, $urandom_range(1, 40));
				1: write_reg(CFG_MAP_HEIGHT, 1024);
				2: write_reg(CFG_MAP_HEIGHT, $urandom_range(1025, 2047));
				default: write_reg(CFG_MAP_HEIGHT, $urandom_range(1, 1023));
			endcase
			eff_w = (map_width_reg > DIM_CAP) ? DIM_CAP : int'(map_width_reg);
			eff_h = (map_height_reg > DIM_CAP) ? DIM_CAP : int'(map_height_reg);
			r = (((brush_size_reg > SIZE_CAP) ? SIZE_CAP : int'(brush_size_reg)) >> 1) + 1;
			for (int i = 0; i < 22; i++) begin
				if ($urandom_range(99) < 75) begin
					cx = int'($urandom_range(eff_w + 2 * r - 1)) - r;
					cy = int'($urandom_range(eff_h + 2 * r - 1)) - r;
				end else begin
					cx = int'($urandom_range(4095)) - 2048;
					cy = int'($urandom_range(4095)) - 2048;
				end
				send_stamp(COORD_W'(cx), COORD_W'(cy), TILE_W'($urandom_range(4095)));
			end
		end
		idle_pct = 0;
		settle();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_BRUSH_SIZE;
		cfg_data <= '0;
		start <= 1'b0;
		center_x <= '0;
		center_y <= '0;
		tile_type <= '0;
		brush_size_reg = 1;
		brush_mode_reg = 0;
		map_width_reg = 1024;
		map_height_reg = 1024;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 11;
		test_reset_defaults();
		test_brush_extremes();
		test_erase_mode();
		test_map_clipping();
		test_random_stamps();

		// Anything still expected never arrived
		if (spans_due.size() != 0)
			report_mismatch($sformatf("%0d spans never arrived", spans_due.size()));
		if (error_count == 0)
			$display("** disk_brush_tile_stamp: PASSED **");
		else
			$display("** disk_brush_tile_stamp: FAILED **");
		$finish;
	end

endmodule
